[src/qse_pkg.sv]
// ----------------------------------------------------------------------------
// qse_pkg
// shared data width, data type and default element count of the quicksort engine
// ----------------------------------------------------------------------------
package qse_pkg;

  localparam int unsigned DataW              = 32;
  localparam int unsigned MaxElementsDefault = 64;

  typedef logic signed [DataW-1:0] qse_data_t;

endpackage

[src/qse_if.sv]
// ----------------------------------------------------------------------------
// qse_in_if / qse_out_if
// valid/ready channels for input elements and sorted results
// ----------------------------------------------------------------------------
interface qse_in_if
  import qse_pkg::*;
;
  logic      valid;
  logic      ready;
  qse_data_t value;
  logic      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface qse_out_if
  import qse_pkg::*;
;
  logic      valid;
  logic      ready;
  qse_data_t sorted_value;
  logic      final_res;
  logic      overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

[src/qse_store.sv]
// ----------------------------------------------------------------------------
// qse_store
// element memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module qse_store
  import qse_pkg::*;
#(
  parameter int unsigned Depth = MaxElementsDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  qse_data_t        wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output qse_data_t        rdata_o
);

  qse_data_t mem [Depth];
  qse_data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/qse_ctrl.sv]
// ----------------------------------------------------------------------------
// qse_ctrl
// load, hoare partition sequencer with one shared comparator, range stack
// and result emission
// ----------------------------------------------------------------------------
module qse_ctrl
  import qse_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDefault,
  parameter int unsigned AddrW       = $clog2(MaxElements)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  qse_in_if.sink           in_i,
  qse_out_if.source        out_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output qse_data_t        mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  qse_data_t        mem_rdata_i
);

  localparam int unsigned IdxW       = AddrW + 2;
  localparam int unsigned CntW       = $clog2(MaxElements + 1);
  localparam int unsigned StackDepth = $clog2(MaxElements) + 1;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned SiW        = $clog2(StackDepth);

  typedef enum logic [13:0] {
    ST_LOAD      = 14'b00000000000001,
    ST_TOP       = 14'b00000000000010,
    ST_RD_PIV    = 14'b00000000000100,
    ST_SCAN_A    = 14'b00000000001000,
    ST_CMP_A     = 14'b00000000010000,
    ST_SCAN_B    = 14'b00000000100000,
    ST_CMP_B     = 14'b00000001000000,
    ST_DECIDE    = 14'b00000010000000,
    ST_SWAP      = 14'b00000100000000,
    ST_PLACE     = 14'b00001000000000,
    ST_PUSH      = 14'b00010000000000,
    ST_EMIT_RD   = 14'b00100000000000,
    ST_EMIT_LD   = 14'b01000000000000,
    ST_EMIT_WAIT = 14'b10000000000000
  } qse_state_e;

  qse_state_e state_q, state_d;

  logic signed [IdxW-1:0] lo_q, lo_d, hi_q, hi_d, a_q, a_d, b_q, b_d;
  logic signed [IdxW-1:0] left_len, right_len;
  logic [CntW-1:0]        count_q, count_d, k_q, k_d;
  logic [SpW-1:0]         sp_q, sp_d, sp_m1;
  logic                   ovf_q, ovf_d;
  qse_data_t              pivot_q, pivot_d, va_q, va_d, vb_q, vb_d;

  logic signed [IdxW-1:0] stk_lo_q [StackDepth];
  logic signed [IdxW-1:0] stk_hi_q [StackDepth];
  logic                   push_en;
  logic signed [IdxW-1:0] push_lo, push_hi;

  logic                   out_valid_q, out_valid_d;
  qse_data_t              out_value_q, out_value_d;
  logic                   out_final_q, out_final_d, out_ovf_q, out_ovf_d;

  logic                   piv_ge;
  logic                   in_xfer, out_xfer;

  // shared compare unit
  assign piv_ge = (pivot_q >= mem_rdata_i);

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign sp_m1    = sp_q - SpW'(1);

  assign left_len  = b_q - lo_q;
  assign right_len = hi_q - b_q;

  assign in_i.ready         = (state_q == ST_LOAD);
  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.final_res    = out_final_q;
  assign out_o.overflow     = out_ovf_q;

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    a_d         = a_q;
    b_d         = b_q;
    count_d     = count_q;
    k_d         = k_q;
    sp_d        = sp_q;
    ovf_d       = ovf_q;
    pivot_d     = pivot_q;
    va_d        = va_q;
    vb_d        = vb_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;
    push_en     = 1'b0;
    push_lo     = lo_q;
    push_hi     = hi_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[AddrW-1:0];
    mem_wdata_o = in_i.value;
    mem_raddr_o = lo_q[AddrW-1:0];

    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (count_q < CntW'(MaxElements)) begin
            mem_we_o = 1'b1;
            count_d  = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            lo_d    = '0;
            hi_d    = $signed(IdxW'(count_d) - IdxW'(1));
            sp_d    = '0;
            state_d = ST_TOP;
          end
        end
      end
      ST_TOP: begin
        if (lo_q < hi_q) begin
          mem_raddr_o = lo_q[AddrW-1:0];
          state_d     = ST_RD_PIV;
        end else if (sp_q == '0) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          sp_d = sp_m1;
          lo_d = stk_lo_q[sp_m1[SiW-1:0]];
          hi_d = stk_hi_q[sp_m1[SiW-1:0]];
        end
      end
      ST_RD_PIV: begin
        pivot_d = mem_rdata_i;
        a_d     = lo_q + IdxW'(1);
        b_d     = hi_q;
        state_d = ST_SCAN_A;
      end
      ST_SCAN_A: begin
        if (a_q < hi_q) begin
          mem_raddr_o = a_q[AddrW-1:0];
          state_d     = ST_CMP_A;
        end else begin
          state_d = ST_SCAN_B;
        end
      end
      ST_CMP_A: begin
        if (piv_ge) begin
          a_d     = a_q + IdxW'(1);
          state_d = ST_SCAN_A;
        end else begin
          va_d    = mem_rdata_i;
          state_d = ST_SCAN_B;
        end
      end
      ST_SCAN_B: begin
        if (b_q > lo_q) begin
          mem_raddr_o = b_q[AddrW-1:0];
          state_d     = ST_CMP_B;
        end else begin
          // the scan stopped on the pivot slot itself
          vb_d    = pivot_q;
          state_d = ST_DECIDE;
        end
      end
      ST_CMP_B: begin
        if (!piv_ge) begin
          b_d     = b_q - IdxW'(1);
          state_d = ST_SCAN_B;
        end else begin
          vb_d    = mem_rdata_i;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = vb_q;
        if (a_q < b_q) begin
          mem_waddr_o = a_q[AddrW-1:0];
          state_d     = ST_SWAP;
        end else begin
          mem_waddr_o = lo_q[AddrW-1:0];
          state_d     = ST_PLACE;
        end
      end
      ST_SWAP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = b_q[AddrW-1:0];
        mem_wdata_o = va_q;
        state_d     = ST_SCAN_A;
      end
      ST_PLACE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = b_q[AddrW-1:0];
        mem_wdata_o = pivot_q;
        state_d     = ST_PUSH;
      end
      ST_PUSH: begin
        // larger side goes on the stack, smaller side is split next
        push_en = 1'b1;
        sp_d    = sp_q + SpW'(1);
        if (left_len > right_len) begin
          push_lo = lo_q;
          push_hi = b_q - IdxW'(1);
          lo_d    = b_q + IdxW'(1);
        end else begin
          push_lo = b_q + IdxW'(1);
          push_hi = hi_q;
          hi_d    = b_q - IdxW'(1);
        end
        state_d = ST_TOP;
      end
      ST_EMIT_RD: begin
        mem_raddr_o = k_q[AddrW-1:0];
        state_d     = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_valid_d = 1'b1;
        out_value_d = mem_rdata_i;
        out_final_d = ((k_q + CntW'(1)) == count_q);
        out_ovf_d   = ovf_q;
        state_d     = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_xfer) begin
          out_valid_d = 1'b0;
          if (out_final_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + CntW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      sp_q        <= '0;
      k_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      sp_q        <= sp_d;
      k_q         <= k_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      a_q         <= a_d;
      b_q         <= b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pivot_q     <= pivot_d;
    va_q        <= va_d;
    vb_q        <= vb_d;
    out_value_q <= out_value_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
    if (push_en) begin
      stk_lo_q[sp_q[SiW-1:0]] <= push_lo;
      stk_hi_q[sp_q[SiW-1:0]] <= push_hi;
    end
  end

  a_out_only_in_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == ST_EMIT_WAIT))
    else $error("result valid outside emission");

  a_stack_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> (sp_q < SpW'(StackDepth)))
    else $error("range stack overflow");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxElements))
    else $error("element count beyond store depth");

  a_scan_a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP_A) |-> (a_q < hi_q && a_q > lo_q))
    else $error("left scan outside subrange");

  a_scan_b_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP_B) |-> (b_q > lo_q && b_q <= hi_q))
    else $error("right scan outside subrange");

endmodule

[src/quicksort_engine_top.sv]
// Timing: one element is loaded per cycle; after the last element the sort reads
// then compares for each pivot compare (about N log N compares), writes both slots
// per swap and reads, places and pushes per subrange; results then come out one at
// a time, each paced by the read, load and handshake steps of the emit sequence.
// Throughput: one run at a time; input is not ready from the last element
// until the final result transfers.
// Reset: control state, count and overflow flag clear; store contents undefined.
// ----------------------------------------------------------------------------
// quicksort_engine_top
// element store plus quicksort sequencer, sorts one run and emits it in order
// ----------------------------------------------------------------------------
module quicksort_engine_top
  import qse_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qse_in_if.sink    in_i,
  qse_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(MaxElements);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  qse_data_t        mem_wdata;
  qse_data_t        mem_rdata;

  qse_ctrl #(
    .MaxElements (MaxElements),
    .AddrW       (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  qse_store #(
    .Depth (MaxElements),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
